// ----- sv/bvf_pkg.sv -----
// ----------------------------------------------------------------------------
// Battery voltage filter package
// Widths, constants, charge-curve tables and shared types.
// ----------------------------------------------------------------------------
package bvf_pkg;

  localparam int FRACTION_BITS = 16;

  // field widths
  localparam int PIN_W   = 22;
  localparam int UV_W    = PIN_W + 1;
  localparam int F_W     = UV_W + FRACTION_BITS;
  localparam int COEF_W  = 16;
  localparam int WARM_W  = 4;
  localparam int MV_W    = 13;
  localparam int CHG_W   = 10;
  localparam int CUR_W   = 16;
  localparam int SLOPE_W = 8;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // serial multiplier
  localparam int MC_W   = F_W + 2;
  localparam int MP_W   = (COEF_W > FRACTION_BITS) ? COEF_W : FRACTION_BITS;
  localparam int STEP_W = $clog2(MP_W + 1);

  // serial divider
  localparam int DIV_N_W = 25;
  localparam int DIV_D_W = 17;

  localparam int SEG_W = 3;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_EMA_COEF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP   = 1'b1;

  localparam logic [COEF_W-1:0] COEF_RESET = 16'd328;
  localparam logic [WARM_W-1:0] WARM_RESET = 4'd5;

  localparam logic [DIV_D_W-1:0] MV_DIVISOR   = 17'd1000;
  localparam logic [DIV_D_W-1:0] STEP_DIVISOR = 17'd100000;

  localparam logic [F_W-1:0] LOW_FX  = F_W'(64'd3500000) << FRACTION_BITS;
  localparam logic [F_W-1:0] HIGH_FX = F_W'(64'd4200000) << FRACTION_BITS;

  localparam logic [MV_W-1:0]  MV_MAX    = 13'd8191;
  localparam logic [CHG_W-1:0] CHG_EMPTY = 10'd0;
  localparam logic [CHG_W-1:0] CHG_FULL  = 10'd1000;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [CHG_W-1:0] seg_base(input logic [SEG_W-1:0] k);
    logic [CHG_W-1:0] b;
    unique case (k)
      3'd0:    b = 10'd0;
      3'd1:    b = 10'd203;
      3'd2:    b = 10'd432;
      3'd3:    b = 10'd622;
      3'd4:    b = 10'd768;
      3'd5:    b = 10'd880;
      3'd6:    b = 10'd978;
      default: b = 10'd0;
    endcase
    return b;
  endfunction

  function automatic logic [SLOPE_W-1:0] seg_slope(input logic [SEG_W-1:0] k);
    logic [SLOPE_W-1:0] s;
    unique case (k)
      3'd0:    s = 8'd203;
      3'd1:    s = 8'd229;
      3'd2:    s = 8'd190;
      3'd3:    s = 8'd146;
      3'd4:    s = 8'd112;
      3'd5:    s = 8'd98;
      3'd6:    s = 8'd22;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- sv/bvf_mul.sv -----
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit a cycle;
// the accumulator shifts right so after n steps it holds floor(a*b / 2^n).
// ----------------------------------------------------------------------------
module bvf_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bvf_pkg::MC_W-1:0]    mcand_i,
  input  logic [bvf_pkg::MP_W-1:0]    mplr_i,
  input  logic [bvf_pkg::STEP_W-1:0]  steps_i,
  output logic [bvf_pkg::MC_W-1:0]    prod_o,
  output bvf_pkg::unit_stat_t         stat_o
);
  import bvf_pkg::*;

  logic [MC_W-1:0]   acc_q, acc_d;
  logic [MC_W-1:0]   mcand_q;
  logic [MP_W-1:0]   mplr_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [MC_W:0]     sum;

  assign sum   = {acc_q[MC_W-1], acc_q}
               + (mplr_q[0] ? {mcand_q[MC_W-1], mcand_q} : {(MC_W + 1){1'b0}});
  assign acc_d = sum[MC_W:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i - STEP_W'(1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= '0;
      mcand_q <= mcand_i;
      mplr_q  <= mplr_i;
    end else if (busy_q) begin
      acc_q  <= acc_d;
      mplr_q <= {1'b0, mplr_q[MP_W-1:1]};
    end
  end

  assign prod_o      = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ----- sv/bvf_div.sv -----
// ----------------------------------------------------------------------------
// Serial restoring divider
// Unsigned division, one quotient bit a cycle, MSB first.
// ----------------------------------------------------------------------------
module bvf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bvf_pkg::DIV_N_W-1:0]  dividend_i,
  input  logic [bvf_pkg::DIV_D_W-1:0]  divisor_i,
  output logic [bvf_pkg::DIV_N_W-1:0]  quotient_o,
  output logic [bvf_pkg::DIV_D_W-1:0]  remainder_o,
  output bvf_pkg::unit_stat_t          stat_o
);
  import bvf_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W);

  logic [DIV_D_W-1:0] rem_q, rem_d;
  logic [DIV_N_W-1:0] quo_q;
  logic [DIV_D_W-1:0] dvs_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q;
  logic [DIV_D_W:0]   trial, diff;
  logic               ge;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[DIV_N_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign rem_d = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_N_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DIV_N_W-2:0], ge};
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ----- sv/battery_voltage_filter_soc.sv -----
// ----------------------------------------------------------------------------
// Battery voltage filter with state-of-charge estimate
// Smooths pin voltage samples and derives millivolts and charge.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pin voltage sample (microvolts) per request. Each
//   sample gives exactly one m_axis result: filtered battery millivolts,
//   charge in tenths of a percent and a current field that is always zero.
//   The user must write the coefficient and warm-up count over the cfg port
//   only while idle; the block itself does not enforce it. One sample is
//   processed at a time by a shared serial multiplier (one multiplier bit a
//   cycle) and a shared serial divider (one quotient bit a cycle). A filtered
//   sample inside the charge curve runs a 16-step multiply, two 25-step
//   divides, a 16-step multiply and a 25-step divide; warm-up samples skip
//   the first multiply, and voltages outside 3.5 V to 4.2 V skip the charge
//   steps. The next request is taken once the result sits in the output
//   register, so no new sample is taken while one is in work.
//   Reset clears the average and the warm-up count and restores the default
//   coefficient (328) and warm-up (5). A stalled receiver holds the result;
//   the next sample is still processed and waits until the slot frees.
// ----------------------------------------------------------------------------
module battery_voltage_filter_soc (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [21:0] pin_microvolts
  input  logic [bvf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [12:0] battery_millivolts, [22:13] charge_tenths, [38:23] current_milliamps
  output logic [bvf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [bvf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bvf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import bvf_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_EMA   = 7'b0000010,
    ST_MV    = 7'b0000100,
    ST_SEG   = 7'b0001000,
    ST_SLOPE = 7'b0010000,
    ST_FRAC  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic                start_q, start_d;
  logic [COEF_W-1:0]   coef_q, coef_d;
  logic [WARM_W-1:0]   warm_q, warm_d;
  logic [WARM_W-1:0]   count_q, count_d;
  logic [F_W-1:0]      filt_q, filt_d;
  logic [F_W-1:0]      samp_q, samp_d;
  logic [MV_W-1:0]     mv_q, mv_d;
  logic [CHG_W-1:0]    chg_q, chg_d;
  logic [SEG_W-1:0]    seg_q, seg_d;
  logic [DIV_D_W-1:0]  r1_q, r1_d;
  logic                m_valid_q, m_valid_d;
  logic [MV_W-1:0]     mv_out_q, mv_out_d;
  logic [CHG_W-1:0]    chg_out_q, chg_out_d;

  logic                in_accept;
  logic                out_free;
  logic [F_W-1:0]      sample_fx;
  logic [F_W-1:0]      above_floor;
  logic [MC_W-1:0]     ema_diff;

  logic                mul_start;
  logic [MC_W-1:0]     mul_mcand;
  logic [MP_W-1:0]     mul_mplr;
  logic [STEP_W-1:0]   mul_steps;
  logic [MC_W-1:0]     mul_prod;
  unit_stat_t          mul_stat;

  logic                div_start;
  logic [DIV_N_W-1:0]  div_dividend;
  logic [DIV_D_W-1:0]  div_divisor;
  logic [DIV_N_W-1:0]  div_quo;
  logic [DIV_D_W-1:0]  div_rem;
  unit_stat_t          div_stat;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // doubled pin voltage with fraction bits
  assign sample_fx   = F_W'({s_axis_tdata[PIN_W-1:0], 1'b0}) << FRACTION_BITS;
  assign ema_diff    = {2'b00, samp_q} - {2'b00, filt_q};
  assign above_floor = filt_q - LOW_FX;

  // operand routing for the shared units
  assign mul_start = start_q && ((state_q == ST_EMA) || (state_q == ST_SLOPE));
  assign div_start = start_q && ((state_q == ST_MV) || (state_q == ST_SEG)
                                 || (state_q == ST_FRAC));

  always_comb begin
    if (state_q == ST_SLOPE) begin
      mul_mcand = MC_W'({r1_q, filt_q[FRACTION_BITS-1:0]});
      mul_mplr  = MP_W'(seg_slope(seg_q));
      mul_steps = STEP_W'(FRACTION_BITS);
    end else begin
      mul_mcand = ema_diff;
      mul_mplr  = MP_W'(coef_q);
      mul_steps = STEP_W'(COEF_W);
    end
  end

  always_comb begin
    case (state_q)
      ST_SEG: begin
        div_dividend = DIV_N_W'(above_floor[F_W-1:FRACTION_BITS]);
        div_divisor  = STEP_DIVISOR;
      end
      ST_FRAC: begin
        div_dividend = mul_prod[DIV_N_W-1:0];
        div_divisor  = STEP_DIVISOR;
      end
      default: begin
        div_dividend = DIV_N_W'(filt_q[F_W-1:FRACTION_BITS]);
        div_divisor  = MV_DIVISOR;
      end
    endcase
  end

  bvf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mcand_i (mul_mcand),
    .mplr_i  (mul_mplr),
    .steps_i (mul_steps),
    .prod_o  (mul_prod),
    .stat_o  (mul_stat)
  );

  bvf_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .stat_o      (div_stat)
  );

  always_comb begin
    state_d   = state_q;
    start_d   = 1'b0;
    coef_d    = coef_q;
    warm_d    = warm_q;
    count_d   = count_q;
    filt_d    = filt_q;
    samp_d    = samp_q;
    mv_d      = mv_q;
    chg_d     = chg_q;
    seg_d     = seg_q;
    r1_d      = r1_q;
    m_valid_d = m_valid_q;
    mv_out_d  = mv_out_q;
    chg_out_d = chg_out_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EMA_COEF: coef_d = cfg_wdata_i[COEF_W-1:0];
        CFG_WARMUP:   warm_d = cfg_wdata_i[WARM_W-1:0];
      endcase
    end

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          samp_d  = sample_fx;
          start_d = 1'b1;
          if (count_q < warm_q) begin
            // seed the average with the raw sample
            count_d = count_q + WARM_W'(1);
            filt_d  = sample_fx;
            state_d = ST_MV;
          end else begin
            state_d = ST_EMA;
          end
        end
      end
      ST_EMA: begin
        if (mul_stat.done) begin
          filt_d  = filt_q + mul_prod[F_W-1:0];
          start_d = 1'b1;
          state_d = ST_MV;
        end
      end
      ST_MV: begin
        if (div_stat.done) begin
          mv_d = (div_quo > DIV_N_W'(MV_MAX)) ? MV_MAX : div_quo[MV_W-1:0];
          if (filt_q < LOW_FX) begin
            chg_d   = CHG_EMPTY;
            state_d = ST_OUT;
          end else if (filt_q >= HIGH_FX) begin
            chg_d   = CHG_FULL;
            state_d = ST_OUT;
          end else begin
            start_d = 1'b1;
            state_d = ST_SEG;
          end
        end
      end
      ST_SEG: begin
        if (div_stat.done) begin
          seg_d   = div_quo[SEG_W-1:0];
          r1_d    = div_rem;
          start_d = 1'b1;
          state_d = ST_SLOPE;
        end
      end
      ST_SLOPE: begin
        if (mul_stat.done) begin
          start_d = 1'b1;
          state_d = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (div_stat.done) begin
          chg_d   = seg_base(seg_q) + div_quo[CHG_W-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output slot frees
        if (out_free) begin
          m_valid_d = 1'b1;
          mv_out_d  = mv_q;
          chg_out_d = chg_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      start_q   <= 1'b0;
      coef_q    <= COEF_RESET;
      warm_q    <= WARM_RESET;
      count_q   <= '0;
      filt_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      start_q   <= start_d;
      coef_q    <= coef_d;
      warm_q    <= warm_d;
      count_q   <= count_d;
      filt_q    <= filt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q    <= samp_d;
    mv_q      <= mv_d;
    chg_q     <= chg_d;
    seg_q     <= seg_d;
    r1_q      <= r1_d;
    mv_out_q  <= mv_out_d;
    chg_out_q <= chg_out_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, {CUR_W{1'b0}}, chg_out_q, mv_out_q};

  // the multiplier and divider take turns
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_start || div_start) |-> !(mul_stat.busy || div_stat.busy))
    else $error("unit started while one is busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> ((state_q == ST_EMA) || (state_q == ST_SLOPE)))
    else $error("multiplier finished outside a multiply step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (chg_out_q <= CHG_FULL))
    else $error("charge above full scale");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while a sample is in work");

endmodule
